FILE: rtl/lcg48_pkg.sv
// ----------------------------------------------------------------------------
// lcg48_pkg
// shared constants, action codes and the command word of the arithmetic unit
// ----------------------------------------------------------------------------
package lcg48_pkg;

  localparam logic [34:0] LCG_MULT = 35'h5DEECE66D;
  localparam logic [47:0] LCG_INC  = 48'hB;

  // request actions
  localparam logic [2:0] ACT_INT  = 3'd0;
  localparam logic [2:0] ACT_BND  = 3'd1;
  localparam logic [2:0] ACT_LONG = 3'd2;
  localparam logic [2:0] ACT_BOOL = 3'd3;
  localparam logic [2:0] ACT_FLT  = 3'd4;
  localparam logic [2:0] ACT_DBL  = 3'd5;

  typedef enum logic [1:0] {
    ALU_NOP   = 2'd0,
    ALU_MUL   = 2'd1,
    ALU_DLOAD = 2'd2,
    ALU_DSTEP = 2'd3
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [34:0] b;
  } alu_cmd_t;

endpackage

FILE: rtl/lcg48_alu.sv
// ----------------------------------------------------------------------------
// lcg48_alu
// shared arithmetic unit: registered 32x35 multiply and one restoring
// remainder step per cycle
// ----------------------------------------------------------------------------
module lcg48_alu import lcg48_pkg::*; (
  input  logic        clk,
  input  alu_cmd_t    cmd,
  output logic [66:0] prod,
  output logic [30:0] rem
);

  logic [30:0] dvd;
  logic [31:0] partial;
  logic [32:0] diff;
  logic [30:0] rem_step;

  // shift in the next dividend bit, subtract the divisor when it fits
  always_comb begin
    partial  = {rem, dvd[30]};
    diff     = {1'b0, partial} - {2'b00, cmd.b[30:0]};
    rem_step = diff[32] ? partial[30:0] : diff[30:0];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ALU_MUL: begin
        prod <= {35'b0, cmd.a} * {32'b0, cmd.b};
      end
      ALU_DLOAD: begin
        dvd <= cmd.a[30:0];
        rem <= '0;
      end
      ALU_DSTEP: begin
        dvd <= {dvd[29:0], 1'b0};
        rem <= rem_step;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/lcg48_random_generator.sv
// ----------------------------------------------------------------------------
// lcg48_random_generator
// 48-bit linear congruential generator with int, bounded, long, boolean
// and fraction draws, built around one shared multiply / remainder unit
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake               | word
//  ---------+-----------+-------------------------+--------------------------
//  seed     | in        | seed_valid / seed_ready | seed_value (48 bits)
//  req      | in        | req_valid  / req_ready  | action (3), bound (31)
//  rsp      | out       | rsp_valid  / rsp_ready  | value (64)
//
//  each state advance runs in the shared 32x35 multiplier (three
//  16-bit partial products of the state, accumulated mod 2^48), then
//  S_EVAL picks the bits; long and double use two state advances, a
//  power-of-two bound adds a multiply-shift, and any other bound runs
//  the 31-step remainder in the shared unit per draw attempt and
//  repeats while a draw is rejected
//  the block takes one request at a time; req_ready is high only when idle,
//  and a finished word waits in the output register so the next request can
//  be taken while the previous word is still stalled on rsp_ready
//  rst is synchronous: the state reloads with the multiplier, as a zero seed
//
module lcg48_random_generator import lcg48_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_valid,
  output logic        seed_ready,
  input  logic [47:0] seed_value,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [2:0]  action,
  input  logic [30:0] bound,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [63:0] value
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_EVAL  = 7'b0000100,
    S_PMUL  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_CHECK = 7'b0100000,
    S_OUT   = 7'b1000000
  } fsm_t;

  fsm_t        fsm;
  logic [47:0] lcg_state;   // generator state
  logic [47:0] acc;         // partial product accumulator
  logic [1:0]  mcnt;        // partial product index
  logic [4:0]  dcnt;        // remainder step count
  logic [2:0]  act_q;
  logic [30:0] bound_q;
  logic        is_pow2;
  logic        second;      // second draw of a long or double
  logic [31:0] hi_word;
  logic [30:0] draw_r;      // bounded draw under test
  logic [63:0] res;

  alu_cmd_t    cmd;
  logic [66:0] prod;
  logic [30:0] rem;

  logic [47:0] addend;
  logic [47:0] acc_sum;
  logic [15:0] chunk;
  logic [31:0] accept_t;
  logic        req_fire;

  lcg48_alu u_alu (
    .clk  (clk),
    .cmd  (cmd),
    .prod (prod),
    .rem  (rem)
  );

  assign req_ready  = (fsm == S_IDLE);
  assign seed_ready = (fsm == S_IDLE);
  assign req_fire   = req_valid && req_ready;

  // product of the previous cycle, placed at its 16-bit offset
  always_comb begin
    case (mcnt)
      2'd1:    addend = prod[47:0];
      2'd2:    addend = {prod[31:0], 16'b0};
      2'd3:    addend = {prod[15:0], 32'b0};
      default: addend = '0;
    endcase
    acc_sum = acc + addend;
  end

  always_comb begin
    case (mcnt)
      2'd0:    chunk = lcg_state[15:0];
      2'd1:    chunk = lcg_state[31:16];
      default: chunk = lcg_state[47:32];
    endcase
  end

  // java-style rejection: overflow of draw - rem + bound - 1 in 32 bits
  assign accept_t = {1'b0, draw_r} - {1'b0, rem} + {1'b0, bound_q} - 32'd1;

  // command for the shared unit
  always_comb begin
    cmd.op = ALU_NOP;
    cmd.a  = '0;
    cmd.b  = '0;
    case (fsm)
      S_MUL: begin
        if (mcnt != 2'd3) begin
          cmd.op = ALU_MUL;
          cmd.a  = {16'b0, chunk};
          cmd.b  = LCG_MULT;
        end
      end
      S_EVAL: begin
        if (act_q == ACT_BND) begin
          cmd.op = is_pow2 ? ALU_MUL : ALU_DLOAD;
          cmd.a  = {1'b0, lcg_state[47:17]};
          cmd.b  = {4'b0, bound_q};
        end
      end
      S_DIV: begin
        cmd.op = ALU_DSTEP;
        cmd.b  = {4'b0, bound_q};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_IDLE;
      lcg_state <= {13'b0, LCG_MULT};
      rsp_valid <= 1'b0;
      mcnt      <= '0;
      dcnt      <= '0;
      second    <= 1'b0;
    end else begin
      // the output state handles its own hand-over of the word
      if (rsp_valid && rsp_ready && fsm != S_OUT) begin
        rsp_valid <= 1'b0;
      end
      case (fsm)
        S_IDLE: begin
          if (seed_valid) begin
            lcg_state <= seed_value ^ {13'b0, LCG_MULT};
          end
          if (req_fire) begin
            act_q   <= action;
            bound_q <= bound;
            is_pow2 <= ((bound & (bound - 31'd1)) == '0);
            second  <= 1'b0;
            mcnt    <= '0;
            acc     <= LCG_INC;
            // unused actions and a zero bound answer 0 without a draw
            if (action > ACT_DBL || (action == ACT_BND && bound == '0)) begin
              res <= '0;
              fsm <= S_OUT;
            end else begin
              fsm <= S_MUL;
            end
          end
        end
        S_MUL: begin
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd3) begin
            lcg_state <= acc_sum;
            fsm       <= S_EVAL;
          end else begin
            acc <= acc_sum;
          end
        end
        S_EVAL: begin
          mcnt <= '0;
          acc  <= LCG_INC;
          case (act_q)
            ACT_INT: begin
              res <= {32'b0, lcg_state[47:16]};
              fsm <= S_OUT;
            end
            ACT_LONG: begin
              if (second) begin
                res <= {hi_word, lcg_state[47:16]};
                fsm <= S_OUT;
              end else begin
                hi_word <= lcg_state[47:16];
                second  <= 1'b1;
                fsm     <= S_MUL;
              end
            end
            ACT_BOOL: begin
              res <= {63'b0, lcg_state[47]};
              fsm <= S_OUT;
            end
            ACT_FLT: begin
              res <= {40'b0, lcg_state[47:24]};
              fsm <= S_OUT;
            end
            ACT_DBL: begin
              if (second) begin
                res <= {11'b0, hi_word[25:0], lcg_state[47:21]};
                fsm <= S_OUT;
              end else begin
                hi_word <= {6'b0, lcg_state[47:22]};
                second  <= 1'b1;
                fsm     <= S_MUL;
              end
            end
            default: begin
              // bounded draw
              draw_r <= lcg_state[47:17];
              dcnt   <= '0;
              fsm    <= is_pow2 ? S_PMUL : S_DIV;
            end
          endcase
        end
        S_PMUL: begin
          res <= {33'b0, prod[61:31]};
          fsm <= S_OUT;
        end
        S_DIV: begin
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd30) begin
            fsm <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (accept_t[31]) begin
            fsm <= S_MUL;   // rejected, draw again
          end else begin
            res <= {33'b0, rem};
            fsm <= S_OUT;
          end
        end
        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            value     <= res;
            rsp_valid <= 1'b1;
            fsm       <= S_IDLE;
          end
        end
        default: begin
          fsm <= S_IDLE;
        end
      endcase
    end
  end

  // a taken request always leaves the idle state
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> !req_ready)
    else $error("still idle after a request was taken");

  // a seed write reloads the state scrambled with the multiplier
  a_seed_load: assert property (@(posedge clk) disable iff (rst)
    (seed_valid && seed_ready && !req_valid) |=>
      lcg_state == ($past(seed_value) ^ {13'b0, LCG_MULT}))
    else $error("seed write did not reload the state");

  // the remainder path is only used for bounds that are not powers of two
  a_div_path: assert property (@(posedge clk) disable iff (rst)
    (fsm == S_DIV || fsm == S_CHECK) |-> (act_q == ACT_BND && !is_pow2))
    else $error("remainder path entered for the wrong request");

  // the multiply-shift path is only used for power-of-two bounds
  a_pow2_path: assert property (@(posedge clk) disable iff (rst)
    (fsm == S_PMUL) |-> (act_q == ACT_BND && is_pow2 && bound_q != '0))
    else $error("multiply-shift path entered for the wrong request");

endmodule
